// ----- src/stlt_pkg.sv -----
`timescale 1ns / 1ps

package stlt_pkg;

  localparam int SLOTS = 8;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int TOK_W = 64;
  localparam int TIME_W = 32;
  localparam int SLOT_OUT_W = 3;

  localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd1800000;

  localparam logic [1:0] CMD_LOGIN    = 2'd0;
  localparam logic [1:0] CMD_LOGOUT   = 2'd1;
  localparam logic [1:0] CMD_VALIDATE = 2'd2;
  localparam logic [1:0] CMD_SWEEP    = 2'd3;

  // controller -> datapath
  typedef struct packed {
    logic load;     // capture transaction, reset scan
    logic step;     // evaluate entry at scan index, advance
    logic commit;   // write login entry
    logic publish;  // move result into output register
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_stop;   // current step is the final one
    logic need_write;  // login with good credentials
  } dp_stat_t;

endpackage

// ----- src/stlt_ctrl.sv -----
`timescale 1ns / 1ps

module stlt_ctrl import stlt_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output ctl_cmd_t cmd_o
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_WRITE = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_valid_next;

  always_comb begin
    state_next     = state;
    cmd_o          = '0;
    in_ready       = 1'b0;
    out_valid_next = out_valid && !out_ready;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd_o.load = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.step = 1'b1;
        if (stat.scan_stop) begin
          state_next = stat.need_write ? S_WRITE : S_DONE;
        end
      end
      S_WRITE: begin
        cmd_o.commit = 1'b1;
        state_next   = S_DONE;
      end
      S_DONE: begin
        // wait until the output register is free
        if (!out_valid || out_ready) begin
          cmd_o.publish  = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ----- src/stlt_dp.sv -----
`timescale 1ns / 1ps

module stlt_dp import stlt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  ctl_cmd_t              cmd_i,
  output dp_stat_t              stat,
  input  logic                  cfg_we,
  input  logic [TIME_W-1:0]     cfg_wdata,
  input  logic [1:0]            cmd,
  input  logic [TOK_W-1:0]      token_high,
  input  logic [TOK_W-1:0]      token_low,
  input  logic                  token_empty,
  input  logic                  credentials_ok,
  input  logic [TIME_W-1:0]     now_ms,
  output logic                  ok,
  output logic [SLOT_OUT_W-1:0] slot,
  output logic                  evicted
);

  // session table
  logic              active    [SLOTS];
  logic [TOK_W-1:0]  tok_hi    [SLOTS];
  logic [TOK_W-1:0]  tok_lo    [SLOTS];
  logic [TIME_W-1:0] last_seen [SLOTS];

  logic [TIME_W-1:0] timeout;

  // captured transaction
  logic [1:0]        op;
  logic [TOK_W-1:0]  th;
  logic [TOK_W-1:0]  tl;
  logic              empty;
  logic              cred;
  logic [TIME_W-1:0] now;

  // scan state
  logic [SLOT_W-1:0] idx;
  logic              found;
  logic [SLOT_W-1:0] pick;
  logic [SLOT_W-1:0] oldest;
  logic [TIME_W-1:0] oldest_ls;
  logic              w_ok;
  logic [SLOT_W-1:0] w_slot;
  logic              w_evicted;

  logic              e_act;
  logic              e_match;
  logic              e_stale;
  logic [TIME_W-1:0] age;
  logic              last;
  logic              hit;
  logic              skip;
  logic [SLOT_W-1:0] target;

  always_comb begin
    e_act   = active[idx];
    e_match = e_act && (tok_hi[idx] == th) && (tok_lo[idx] == tl);
    age     = now - last_seen[idx];
    e_stale = age > timeout;
    last    = (idx == SLOT_W'(SLOTS - 1));
    hit     = ((op == CMD_LOGIN) && cred && !e_act) ||
              ((op == CMD_VALIDATE) && !empty && e_match);
    skip    = ((op == CMD_LOGIN) && !cred) || ((op == CMD_VALIDATE) && empty);
    target  = found ? pick : oldest;
    stat.scan_stop  = last || hit || skip;
    stat.need_write = (op == CMD_LOGIN) && cred;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      timeout <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        active[i] <= 1'b0;
      end
    end else if (cmd_i.step) begin
      unique case (op)
        CMD_LOGIN: ;
        CMD_LOGOUT: begin
          if (!empty && e_match) begin
            active[idx] <= 1'b0;
          end
        end
        CMD_VALIDATE: begin
          if (!empty && e_match && e_stale) begin
            active[idx] <= 1'b0;
          end
        end
        CMD_SWEEP: begin
          if (e_act && e_stale) begin
            active[idx] <= 1'b0;
          end
        end
        default: ;
      endcase
    end else if (cmd_i.commit) begin
      active[target] <= 1'b1;
    end
  end

  // entry payload, no reset
  always_ff @(posedge clk) begin
    if (cmd_i.step && (op == CMD_VALIDATE) && !empty && e_match && !e_stale) begin
      last_seen[idx] <= now;
    end else if (cmd_i.commit) begin
      last_seen[target] <= now;
      tok_hi[target]    <= th;
      tok_lo[target]    <= tl;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.load) begin
      op        <= cmd;
      th        <= token_high;
      tl        <= token_low;
      empty     <= token_empty;
      cred      <= credentials_ok;
      now       <= now_ms;
      idx       <= '0;
      found     <= 1'b0;
      w_ok      <= (cmd == CMD_LOGOUT) || (cmd == CMD_SWEEP);
      w_slot    <= '0;
      w_evicted <= 1'b0;
    end else if (cmd_i.step) begin
      if (!last) begin
        idx <= idx + 1'b1;
      end
      if ((op == CMD_LOGIN) && cred) begin
        if (!e_act) begin
          found <= 1'b1;
          pick  <= idx;
        end else if ((idx == '0) || (last_seen[idx] < oldest_ls)) begin
          oldest    <= idx;
          oldest_ls <= last_seen[idx];
        end
      end
      if ((op == CMD_VALIDATE) && !empty && e_match) begin
        w_slot <= idx;
        w_ok   <= !e_stale;
      end
    end else if (cmd_i.commit) begin
      w_ok      <= 1'b1;
      w_slot    <= target;
      w_evicted <= !found;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.publish) begin
      ok      <= w_ok;
      slot    <= SLOT_OUT_W'(w_slot);
      evicted <= w_evicted;
    end
  end

endmodule

// ----- src/session_table_lru_timeout.sv -----
`timescale 1ns / 1ps

// Session table, eight entries, least-recently-seen eviction, sliding timeout.
// Input channel (in_valid/in_ready) carries one command transaction: login,
// logout, validate or sweep, with a 128-bit token and the current time.
// Output channel (out_valid/out_ready) returns one transaction per command:
// ok, slot and evicted.
// Each command is captured, then the scan visits one entry per cycle (up to
// SLOTS = 8; login and validate stop at their hit), a login writes its entry,
// and the result is loaded into the output register.
// in_ready is high only while the controller is idle. A new command is taken
// while a previous result still waits in the output register; if the receiver
// stalls, the finished command parks until the output register frees up.
// Reset (rst, synchronous) clears all active flags, sets the timeout to
// 1800000 ms and empties the output register. The timeout is written through
// cfg_we/cfg_wdata; the user must do so while idle, unenforced by the block.
module session_table_lru_timeout import stlt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [TIME_W-1:0]     cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            cmd,
  input  logic [TOK_W-1:0]      token_high,
  input  logic [TOK_W-1:0]      token_low,
  input  logic                  token_empty,
  input  logic                  credentials_ok,
  input  logic [TIME_W-1:0]     now_ms,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  ok,
  output logic [SLOT_OUT_W-1:0] slot,
  output logic                  evicted
);

  ctl_cmd_t ctl;
  dp_stat_t stat;

  // sequencing: idle, scan, login write, result hand-off
  stlt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd_o     (ctl)
  );

  // table storage, per-entry compare, result register
  stlt_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd_i          (ctl),
    .stat           (stat),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .cmd            (cmd),
    .token_high     (token_high),
    .token_low      (token_low),
    .token_empty    (token_empty),
    .credentials_ok (credentials_ok),
    .now_ms         (now_ms),
    .ok             (ok),
    .slot           (slot),
    .evicted        (evicted)
  );

`ifndef SYNTHESIS
  // one command in flight: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("in_ready high right after accepting a transaction");

  // an eviction only comes from a successful login
  a_evict_implies_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && evicted) |-> ok)
    else $error("evicted result without ok");

  // a new result is only published while the controller is busy
  a_publish_when_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result published while idle");
`endif

endmodule

// ----- verif/tb_session_table_lru_timeout.sv -----
`timescale 1ns / 1ps

// Self-checking bench for the session table: a scoreboard keeps its own copy of the
// table, predicts one reply per accepted command and checks replies in order.
module tb_session_table_lru_timeout;
  import stlt_pkg::*;

  localparam int HOLD_CYCLES = 400;  // long receiver hold-off, forces input backpressure
  localparam int SETTLE      = 16;   // extra wait in drain() after the last reply
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 242;
  localparam int POOL        = 10;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [TIME_W-1:0]     cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [1:0]            cmd = CMD_LOGIN;
  logic [TOK_W-1:0]      token_high = '0;
  logic [TOK_W-1:0]      token_low = '0;
  logic                  token_empty = 1'b0;
  logic                  credentials_ok = 1'b0;
  logic [TIME_W-1:0]     now_ms = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  ok;
  logic [SLOT_OUT_W-1:0] slot;
  logic                  evicted;

  session_table_lru_timeout dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .cmd            (cmd),
    .token_high     (token_high),
    .token_low      (token_low),
    .token_empty    (token_empty),
    .credentials_ok (credentials_ok),
    .now_ms         (now_ms),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .ok             (ok),
    .slot           (slot),
    .evicted        (evicted)
  );

  typedef struct packed {
    logic                  ok;
    logic [SLOT_OUT_W-1:0] slot;
    logic                  evicted;
  } reply_t;

  // Shadow session table plus the queue of replies still owed by the block.
  class session_scoreboard;
    bit                active[SLOTS];
    logic [TOK_W-1:0]  tok_hi[SLOTS];
    logic [TOK_W-1:0]  tok_lo[SLOTS];
    logic [TIME_W-1:0] seen[SLOTS];
    logic [TIME_W-1:0] timeout;
    reply_t            owed[$];
    int                errors;

    function new();
      foreach (active[i]) active[i] = 1'b0;
      timeout = TIMEOUT_RESET;
      errors = 0;
    endfunction

    function void set_timeout(logic [TIME_W-1:0] v);
      timeout = v;
    endfunction

    function int pending();
      return owed.size();
    endfunction

    function void report(string what);
      errors++;
      if (errors <= 100) $display("[%0t] check failed: %s", $time, what);
    endfunction

    // age wraps at 32 bits, stale only when strictly older than the timeout
    function bit is_stale(int i, logic [TIME_W-1:0] now);
      logic [TIME_W-1:0] age;
      age = now - seen[i];
      return age > timeout;
    endfunction

    function bit holds(int i, logic [TOK_W-1:0] th, logic [TOK_W-1:0] tl);
      return active[i] && tok_hi[i] == th && tok_lo[i] == tl;
    endfunction

    // Called on every accepted command transaction; applies it to the shadow
    // table and queues the reply the block owes for it.
    function void note_command(logic [1:0] c, logic [TOK_W-1:0] th, logic [TOK_W-1:0] tl,
                               logic emp, logic cred, logic [TIME_W-1:0] now);
      reply_t r;
      int     pick;
      int     oldest;
      bit     hit;
      r = '0;
      pick = -1;
      oldest = 0;
      hit = 1'b0;
      case (c)
        CMD_LOGIN: begin
          // token_empty means nothing here, the token is stored as given
          if (cred) begin
            for (int i = 0; i < SLOTS; i++) begin
              if (pick < 0) begin
                if (!active[i]) pick = i;
                else if (seen[i] < seen[oldest]) oldest = i;
              end
            end
            if (pick < 0) begin
              pick = oldest;
              r.evicted = 1'b1;
            end
            tok_hi[pick] = th;
            tok_lo[pick] = tl;
            seen[pick] = now;
            active[pick] = 1'b1;
            r.ok = 1'b1;
            r.slot = SLOT_OUT_W'(pick);
          end
        end
        CMD_LOGOUT: begin
          if (!emp) begin
            for (int i = 0; i < SLOTS; i++)
              if (holds(i, th, tl)) active[i] = 1'b0;
          end
          r.ok = 1'b1;
        end
        CMD_VALIDATE: begin
          if (!emp) begin
            for (int i = 0; i < SLOTS; i++) begin
              if (!hit && holds(i, th, tl)) begin
                hit = 1'b1;
                r.slot = SLOT_OUT_W'(i);
                if (is_stale(i, now)) begin
                  active[i] = 1'b0;
                end else begin
                  seen[i] = now;
                  r.ok = 1'b1;
                end
              end
            end
          end
        end
        default: begin
          for (int i = 0; i < SLOTS; i++)
            if (active[i] && is_stale(i, now)) active[i] = 1'b0;
          r.ok = 1'b1;
        end
      endcase
      owed.push_back(r);
    endfunction

    function void check_reply(logic o, logic [SLOT_OUT_W-1:0] s, logic e);
      reply_t want;
      if (owed.size() == 0) begin
        report("reply with no command outstanding");
        return;
      end
      want = owed.pop_front();
      if (o !== want.ok) report($sformatf("ok got %b want %b", o, want.ok));
      if (s !== want.slot) report($sformatf("slot got %0d want %0d", s, want.slot));
      if (e !== want.evicted) report($sformatf("evicted got %b want %b", e, want.evicted));
    endfunction
  endclass

  session_scoreboard sb;

  // Idle rates in percent, switched per phase.
  int tx_idle_pct = 12;
  int rx_idle_pct = 47;

  // Hold-off request from the stimulus side; the receiver owns the counter.
  bit hold_req = 1'b0;
  bit hold_taken = 1'b0;
  int hold_left = 0;

  // Session pool for the random part, plus the running clock fed to now_ms.
  logic [TOK_W-1:0]  pool_hi[POOL];
  logic [TOK_W-1:0]  pool_lo[POOL];
  logic [TIME_W-1:0] clock_now = '0;
  logic [TIME_W-1:0] cur_timeout = TIMEOUT_RESET;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Receiver: random ready, except for one long hold-off stretch.
  always @(posedge clk) begin
    if (hold_req && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Monitor: both channels sampled on the edge where the transaction happens.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready)
        sb.note_command(cmd, token_high, token_low, token_empty, credentials_ok, now_ms);
      if (out_valid && out_ready)
        sb.check_reply(ok, slot, evicted);
    end
  end

  // Present one command and hold it until the block takes it. Valid stays high on
  // return so back-to-back transactions never drop it.
  task automatic send_cmd(logic [1:0] c, logic [TOK_W-1:0] th, logic [TOK_W-1:0] tl,
                          logic emp, logic cred, logic [TIME_W-1:0] now);
    in_valid <= 1'b1;
    cmd <= c;
    token_high <= th;
    token_low <= tl;
    token_empty <= emp;
    credentials_ok <= cred;
    now_ms <= now;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic sender_pause();
    int n;
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      n = $urandom_range(6, 1);
      repeat (n) @(posedge clk);
    end
  endtask

  // Wait until every owed reply is back and the block has settled. The first
  // edge lets the monitor log the last accepted command.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Only called while the block is idle.
  task automatic write_timeout(logic [TIME_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_timeout(v);
    cur_timeout = v;
  endtask

  // Directed walk through the corner cases at the reset timeout.
  task automatic run_directed();
    logic [TOK_W-1:0]  k_hi[10];
    logic [TOK_W-1:0]  k_lo[10];
    logic [TIME_W-1:0] t;
    t = TIMEOUT_RESET;
    foreach (k_hi[i]) begin
      k_hi[i] = {$urandom, $urandom};
      k_lo[i] = {$urandom, $urandom};
    end
    k_hi[0] = '0;
    k_lo[0] = '0;
    k_hi[1] = '1;
    k_lo[1] = '1;
    // bad credentials on an empty table, then logout and sweep with nothing in it
    send_cmd(CMD_LOGIN, k_hi[2], k_lo[2], 1'b0, 1'b0, 32'd1000);
    send_cmd(CMD_LOGOUT, k_hi[2], k_lo[2], 1'b0, 1'b1, 32'd1000);
    send_cmd(CMD_SWEEP, '0, '0, 1'b0, 1'b0, 32'd1000);
    // fill all eight slots; token 2 goes in twice, once with the empty flag set
    send_cmd(CMD_LOGIN, k_hi[0], k_lo[0], 1'b0, 1'b1, 32'd5000);
    send_cmd(CMD_LOGIN, k_hi[1], k_lo[1], 1'b0, 1'b1, 32'd5000);
    send_cmd(CMD_LOGIN, k_hi[2], k_lo[2], 1'b1, 1'b1, 32'd5000);
    send_cmd(CMD_LOGIN, k_hi[2], k_lo[2], 1'b0, 1'b1, 32'd6000);
    send_cmd(CMD_LOGIN, k_hi[4], k_lo[4], 1'b0, 1'b1, 32'd7000);
    send_cmd(CMD_LOGIN, k_hi[5], k_lo[5], 1'b0, 1'b1, 32'd7000);
    send_cmd(CMD_LOGIN, k_hi[6], k_lo[6], 1'b0, 1'b1, 32'd8000);
    send_cmd(CMD_LOGIN, k_hi[7], k_lo[7], 1'b0, 1'b1, 32'd9000);
    // full table: evicts the oldest, lowest slot on a three-way tie
    send_cmd(CMD_LOGIN, k_hi[8], k_lo[8], 1'b0, 1'b1, 32'd10000);
    // empty-flag validate, fresh hit on the first duplicate, age equal to timeout,
    // then age one past it
    send_cmd(CMD_VALIDATE, k_hi[2], k_lo[2], 1'b1, 1'b0, 32'd10000);
    send_cmd(CMD_VALIDATE, k_hi[2], k_lo[2], 1'b0, 1'b0, 32'd10000);
    send_cmd(CMD_VALIDATE, k_hi[1], k_lo[1], 1'b0, 1'b0, 32'd5000 + t);
    send_cmd(CMD_VALIDATE, k_hi[4], k_lo[4], 1'b0, 1'b0, 32'd7001 + t);
    // logout: empty flag is a no-op, real one clears both copies
    send_cmd(CMD_LOGOUT, k_hi[2], k_lo[2], 1'b1, 1'b0, 32'd10000);
    send_cmd(CMD_LOGOUT, k_hi[2], k_lo[2], 1'b0, 1'b0, 32'd10000);
    // one-bit near miss never matches
    send_cmd(CMD_VALIDATE, k_hi[5], k_lo[5] ^ 64'd1, 1'b0, 1'b0, 32'd10000);
    send_cmd(CMD_SWEEP, '0, '0, 1'b0, 1'b0, 32'd9001 + t);
    send_cmd(CMD_LOGIN, k_hi[9], k_lo[9], 1'b0, 1'b0, 32'd20000);
    // time wrap: short wrapped age stays fresh, old entry reads as very stale
    send_cmd(CMD_LOGIN, k_hi[9], k_lo[9], 1'b0, 1'b1, 32'hFFFF_FFF0);
    send_cmd(CMD_VALIDATE, k_hi[9], k_lo[9], 1'b0, 1'b0, 32'h0000_0010);
    send_cmd(CMD_VALIDATE, k_hi[8], k_lo[8], 1'b0, 1'b0, 32'h0000_0010);
    send_cmd(CMD_SWEEP, '1, '1, 1'b1, 1'b1, 32'hFFFF_FFFF);
  endtask

  task automatic new_pool();
    foreach (pool_hi[i]) begin
      case ($urandom_range(9))
        0: begin
          pool_hi[i] = '0;
          pool_lo[i] = '0;
        end
        1: begin
          pool_hi[i] = '1;
          pool_lo[i] = '1;
        end
        default: begin
          pool_hi[i] = {$urandom, $urandom};
          pool_lo[i] = {$urandom, $urandom};
        end
      endcase
    end
  endtask

  // Mostly real session traffic on a small token pool so that logins, hits,
  // refreshes, expiries and evictions all happen; a slice of pure noise.
  task automatic send_random_cmd();
    logic [1:0]        c;
    logic [TOK_W-1:0]  th;
    logic [TOK_W-1:0]  tl;
    logic              emp;
    logic              cred;
    int                r;
    int                k;
    r = $urandom_range(99);
    k = $urandom_range(POOL - 1);
    th = pool_hi[k];
    tl = pool_lo[k];
    emp = ($urandom_range(99) < 8);
    cred = ($urandom_range(99) < 88);
    if (r < 36) c = CMD_LOGIN;
    else if (r < 70) c = CMD_VALIDATE;
    else if (r < 82) c = CMD_LOGOUT;
    else c = CMD_SWEEP;
    r = $urandom_range(99);
    if (r < 7) begin
      if ($urandom_range(1)) th = th ^ (64'd1 << $urandom_range(63));
      else tl = tl ^ (64'd1 << $urandom_range(63));
    end else if (r < 15) begin
      th = {$urandom, $urandom};
      tl = {$urandom, $urandom};
    end
    // time: mostly steps scaled to the timeout, some repeats (LRU ties), some jumps
    r = $urandom_range(99);
    if (r < 3) clock_now = $urandom;
    else if (r >= 9) begin
      if (cur_timeout > 32'h4000_0000) clock_now = clock_now + $urandom;
      else clock_now = clock_now + $urandom_range(cur_timeout / 3 + 2);
    end
    if ($urandom_range(99) < 8) begin
      c = 2'($urandom_range(3));
      emp = 1'($urandom_range(1));
      cred = 1'($urandom_range(1));
      send_cmd(c, {$urandom, $urandom}, {$urandom, $urandom}, emp, cred, $urandom);
    end else begin
      send_cmd(c, th, tl, emp, cred, clock_now);
    end
  endtask

  initial begin
    logic [TIME_W-1:0] phase_timeout[PHASES];
    sb = new();
    phase_timeout[0] = 32'd1500;
    phase_timeout[1] = 32'd0;
    phase_timeout[2] = 32'hFFFF_FFFF;
    phase_timeout[3] = 32'd40000;
    phase_timeout[4] = $urandom_range(5000, 1);
    phase_timeout[5] = TIMEOUT_RESET;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_directed();
    drain();

    for (int p = 0; p < PHASES; p++) begin
      // two phases each: sender light/receiver heavy, swapped, then no idling
      if (p < 2) begin
        tx_idle_pct = 12;
        rx_idle_pct <= 47;
      end else if (p < 4) begin
        tx_idle_pct = 47;
        rx_idle_pct <= 12;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
      end
      write_timeout(phase_timeout[p]);
      new_pool();
      clock_now = (p == 1) ? 32'hFFFF_FF00 : $urandom;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 0 && n == 40) hold_req <= 1'b1;
        sender_pause();
        send_random_cmd();
      end
      drain();
    end

    if (sb.pending() != 0) sb.report($sformatf("%0d replies never arrived", sb.pending()));
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ----- session_table_lru_timeout.f -----
src/stlt_pkg.sv
src/stlt_ctrl.sv
src/stlt_dp.sv
src/session_table_lru_timeout.sv
verif/tb_session_table_lru_timeout.sv
